// ===== rtl/tcc_pkg.sv =====
// tcc_pkg: shared types and constants of the text console cursor control block
// command and status structs between controller and datapath, opcodes, result kinds
// no dependencies
`default_nettype none

package tcc_pkg;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_MOVE  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [1:0] KIND_DRAW   = 2'd0;
   localparam logic [1:0] KIND_SCROLL = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;
   localparam logic [1:0] KIND_CURSOR = 2'd3;

   localparam logic [7:0] CHR_BS     = 8'd8;
   localparam logic [7:0] CHR_TAB    = 8'd9;
   localparam logic [7:0] CHR_LF     = 8'd10;
   localparam logic [7:0] CHR_SPACE  = 8'd32;
   localparam logic [7:0] CTRL_LAST  = 8'd31;
   localparam logic [7:0] SCROLL_CLR = 8'h07;

   localparam logic [2:0] CLS_PRINT   = 3'd0;
   localparam logic [2:0] CLS_NEWLINE = 3'd1;
   localparam logic [2:0] CLS_TAB     = 3'd2;
   localparam logic [2:0] CLS_BS      = 3'd3;
   localparam logic [2:0] CLS_OTHER   = 3'd4;

   localparam logic [2:0] OUT_DRAW   = 3'd0;
   localparam logic [2:0] OUT_ERASE  = 3'd1;
   localparam logic [2:0] OUT_SCROLL = 3'd2;
   localparam logic [2:0] OUT_CLEAR  = 3'd3;
   localparam logic [2:0] OUT_REPORT = 3'd4;

   localparam logic [3:0] CUR_NONE   = 4'd0;
   localparam logic [3:0] CUR_SAT    = 4'd1;
   localparam logic [3:0] CUR_ADV    = 4'd2;
   localparam logic [3:0] CUR_TAB    = 4'd3;
   localparam logic [3:0] CUR_BS     = 4'd4;
   localparam logic [3:0] CUR_DOWN   = 4'd5;
   localparam logic [3:0] CUR_BOTTOM = 4'd6;
   localparam logic [3:0] CUR_HOME   = 4'd7;
   localparam logic [3:0] CUR_MOVE   = 4'd8;

   localparam logic [2:0] MEM_NONE      = 3'd0;
   localparam logic [2:0] MEM_RD_CUR    = 3'd1;
   localparam logic [2:0] MEM_WR_DRAW   = 3'd2;
   localparam logic [2:0] MEM_WR_BS     = 3'd3;
   localparam logic [2:0] MEM_RD_SWEEP  = 3'd4;
   localparam logic [2:0] MEM_WR_SWEEP  = 3'd5;
   localparam logic [2:0] MEM_WR_BOTTOM = 3'd6;
   localparam logic [2:0] MEM_WR_CLR    = 3'd7;

   localparam logic [1:0] SWP_HOLD = 2'd0;
   localparam logic [1:0] SWP_ZERO = 2'd1;
   localparam logic [1:0] SWP_ONE  = 2'd2;
   localparam logic [1:0] SWP_INC  = 2'd3;

   localparam logic [7:0] CSR_COLUMNS = 8'd0;
   localparam logic [7:0] CSR_ROWS    = 8'd1;

   typedef struct packed {
      logic       item_load;
      logic       out_load;
      logic [2:0] out_sel;
      logic [3:0] cur_op;
      logic [2:0] mem_op;
      logic [1:0] sweep_op;
   } tcc_cmd_type;

   typedef struct packed {
      logic       out_free;
      logic [2:0] char_class;
      logic       wrap;
      logic       tab_wrap;
      logic       bs_home;
      logic       scroll_needed;
      logic       rows_multi;
      logic       scr_more;
      logic       clr_last;
   } tcc_stat_type;

endpackage

`default_nettype wire

// ===== rtl/text_console_cursor_control.sv =====
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tuser opcode, tdata char/color/target
// rsp      out  rsp_tvalid/rsp_tready  tuser kind, tdata cell fields, tlast
// csr      in   csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// one beat at a time; the next beat is accepted only once the controller sequence is back in idle:
// printable, tab, backspace or ignored character: saturate cursor, read row length, execute, then a
// newline step for newline or wrap, report; move cursor: move, report; opcode 3: report only; a scroll
// copies each row length in the ram up a row, a read and a write per row, then zeroes the bottom row;
// clear screen sweeps the row length ram; after reset the same sweep runs before the first beat is taken
// a stalled rsp holds the sequence; the result register frees as soon as it is taken
// top level: controller plus datapath, depends on tcc_pkg, tcc_ctrl, tcc_dp, tcc_ram
`default_nettype none

module text_console_cursor_control
   import tcc_pkg::*;
#(
   parameter int MAX_ROW_COUNT = 256,
   parameter int MAX_COL_COUNT = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // char_code, color, target_col, target_row
   input  wire logic [1:0]  req_tuser,   // opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // cell_col, cell_row, cell_char, cell_color
   output logic [1:0]       rsp_tuser,   // kind
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [8:0]  csr_data
);

   tcc_cmd_type  cmd;
   tcc_stat_type stat;

   assign csr_ready = 1'b1;

   tcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

   tcc_dp #(
      .MAX_ROW_COUNT (MAX_ROW_COUNT),
      .MAX_COL_COUNT (MAX_COL_COUNT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/tcc_ram.sv =====
// tcc_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module tcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/tcc_dp.sv =====
// tcc_dp: datapath with cursor, config registers, row length ram and result register
// depends on tcc_pkg and tcc_ram
`default_nettype none

module tcc_dp
   import tcc_pkg::*;
#(
   parameter int MAX_ROW_COUNT = 256,
   parameter int MAX_COL_COUNT = 128
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire tcc_cmd_type  cmd,
   output tcc_stat_type      stat,
   input  wire logic [31:0]  req_tdata,
   input  wire logic         csr_valid,
   input  wire logic [7:0]   csr_index,
   input  wire logic [8:0]   csr_data,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast
);

   localparam int RowAw  = (MAX_ROW_COUNT > 1) ? $clog2(MAX_ROW_COUNT) : 1;
   localparam int ColLim = (MAX_COL_COUNT > 128) ? 128 : ((MAX_COL_COUNT < 1) ? 1 : MAX_COL_COUNT);
   localparam int RowLim = (MAX_ROW_COUNT > 256) ? 256 : ((MAX_ROW_COUNT < 1) ? 1 : MAX_ROW_COUNT);
   localparam logic [7:0] ColLim8 = 8'(ColLim);
   localparam logic [8:0] RowLim9 = 9'(RowLim);
   localparam logic [8:0] SweepEnd = 9'(RowLim - 1);

   logic [7:0] columns_ff;
   logic [8:0] rows_ff;
   logic [6:0] cur_col_ff, cur_col_in;
   logic [7:0] cur_row_ff, cur_row_in;
   logic [8:0] sweep_ff, sweep_in;
   logic [7:0] char_ff, color_ff, trow_ff;
   logic [6:0] tcol_ff;

   logic       out_valid_ff;
   logic [1:0] out_kind_ff;
   logic [6:0] out_col_ff;
   logic [7:0] out_row_ff, out_char_ff, out_color_ff;
   logic       out_last_ff;

   logic [7:0] ncols;
   logic [8:0] nrows;
   logic [6:0] last_col;
   logic [7:0] last_row;
   logic [6:0] sat_col;
   logic [7:0] sat_row;
   logic [7:0] col8, col_inc, tab_nc;
   logic [8:0] row_inc;
   logic [7:0] len_q;
   logic [6:0] bs_col;
   logic [7:0] bs_row;
   logic [2:0] char_class;
   logic       out_free;

   logic             wr_en, rd_en;
   logic [7:0]       wr_row, rd_row;
   logic [7:0]       wr_data;
   logic [8:0]       sweep_dec;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= 8'd80;
         rows_ff    <= 9'd25;
      end else if (csr_valid) begin
         if (csr_index == CSR_COLUMNS) begin
            columns_ff <= csr_data[7:0];
         end else if (csr_index == CSR_ROWS) begin
            rows_ff <= csr_data;
         end
      end
   end

   always_comb begin
      if (columns_ff > ColLim8) begin
         ncols = ColLim8;
      end else if (columns_ff == 8'd0) begin
         ncols = 8'd1;
      end else begin
         ncols = columns_ff;
      end
      if (rows_ff > RowLim9) begin
         nrows = RowLim9;
      end else if (rows_ff == 9'd0) begin
         nrows = 9'd1;
      end else begin
         nrows = rows_ff;
      end
   end

   assign last_col = 7'(ncols - 8'd1);
   assign last_row = 8'(nrows - 9'd1);
   assign sat_col  = (cur_col_ff > last_col) ? last_col : cur_col_ff;
   assign sat_row  = (cur_row_ff > last_row) ? last_row : cur_row_ff;
   assign col8     = {1'b0, cur_col_ff};
   assign col_inc  = col8 + 8'd1;
   assign tab_nc   = col8 + (cur_col_ff[0] ? 8'd1 : 8'd2);
   assign row_inc  = {1'b0, cur_row_ff} + 9'd1;

   always_comb begin
      if ((char_ff > CTRL_LAST) && !char_ff[7]) begin
         char_class = CLS_PRINT;
      end else if (char_ff == CHR_LF) begin
         char_class = CLS_NEWLINE;
      end else if (char_ff == CHR_TAB) begin
         char_class = CLS_TAB;
      end else if (char_ff == CHR_BS) begin
         char_class = CLS_BS;
      end else begin
         char_class = CLS_OTHER;
      end
   end

   // backspace landing cell
   always_comb begin
      if (cur_col_ff == 7'd0) begin
         bs_row = cur_row_ff - 8'd1;
         bs_col = (len_q > {1'b0, last_col}) ? last_col : len_q[6:0];
      end else begin
         bs_row = cur_row_ff;
         bs_col = cur_col_ff - 7'd1;
      end
   end

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      stat.out_free      = out_free;
      stat.char_class    = char_class;
      stat.wrap          = col_inc >= ncols;
      stat.tab_wrap      = tab_nc >= ncols;
      stat.bs_home       = (cur_col_ff == 7'd0) && (cur_row_ff == 8'd0);
      stat.scroll_needed = row_inc >= nrows;
      stat.rows_multi    = nrows > 9'd1;
      stat.scr_more      = (sweep_ff + 9'd1) < nrows;
      stat.clr_last      = sweep_ff == SweepEnd;
   end

   // row length ram ports
   assign sweep_dec = sweep_ff - 9'd1;

   always_comb begin
      rd_en   = 1'b0;
      rd_row  = cur_row_ff;
      wr_en   = 1'b0;
      wr_row  = cur_row_ff;
      wr_data = 8'd0;
      unique case (cmd.mem_op)
         MEM_NONE: begin
         end
         MEM_RD_CUR: begin
            rd_en = 1'b1;
            if ((char_class == CLS_BS) && (cur_col_ff == 7'd0) && (cur_row_ff != 8'd0)) begin
               rd_row = cur_row_ff - 8'd1;
            end
         end
         MEM_WR_DRAW: begin
            wr_en   = col_inc > len_q;
            wr_data = col_inc;
         end
         MEM_WR_BS: begin
            wr_en   = {1'b0, bs_col} < len_q;
            wr_row  = bs_row;
            wr_data = {1'b0, bs_col};
         end
         MEM_RD_SWEEP: begin
            rd_en  = 1'b1;
            rd_row = sweep_ff[7:0];
         end
         MEM_WR_SWEEP: begin
            wr_en   = 1'b1;
            wr_row  = sweep_dec[7:0];
            wr_data = len_q;
         end
         MEM_WR_BOTTOM: begin
            wr_en  = 1'b1;
            wr_row = last_row;
         end
         MEM_WR_CLR: begin
            wr_en  = 1'b1;
            wr_row = sweep_ff[7:0];
         end
         default: begin
         end
      endcase
   end

   tcc_ram #(
      .WIDTH (8),
      .DEPTH (MAX_ROW_COUNT)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_row[RowAw-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_row[RowAw-1:0]),
      .rd_data (len_q)
   );

   // cursor
   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      unique case (cmd.cur_op)
         CUR_NONE: begin
         end
         CUR_SAT: begin
            cur_col_in = sat_col;
            cur_row_in = sat_row;
         end
         CUR_ADV: begin
            cur_col_in = col_inc[6:0];
         end
         CUR_TAB: begin
            cur_col_in = tab_nc[6:0];
         end
         CUR_BS: begin
            cur_col_in = bs_col;
            cur_row_in = bs_row;
         end
         CUR_DOWN: begin
            cur_col_in = 7'd0;
            cur_row_in = row_inc[7:0];
         end
         CUR_BOTTOM: begin
            cur_col_in = 7'd0;
            cur_row_in = last_row;
         end
         CUR_HOME: begin
            cur_col_in = 7'd0;
            cur_row_in = 8'd0;
         end
         CUR_MOVE: begin
            cur_col_in = (tcol_ff > last_col) ? last_col : tcol_ff;
            cur_row_in = (trow_ff > last_row) ? last_row : trow_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      unique case (cmd.sweep_op)
         SWP_HOLD: sweep_in = sweep_ff;
         SWP_ZERO: sweep_in = 9'd0;
         SWP_ONE:  sweep_in = 9'd1;
         SWP_INC:  sweep_in = sweep_ff + 9'd1;
         default:  sweep_in = sweep_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff   <= 7'd0;
         cur_row_ff   <= 8'd0;
         sweep_ff     <= 9'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         sweep_ff   <= sweep_in;
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // latched request beat
   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         char_ff  <= req_tdata[7:0];
         color_ff <= req_tdata[15:8];
         tcol_ff  <= req_tdata[22:16];
         trow_ff  <= req_tdata[30:23];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_last_ff <= 1'b0;
         unique case (cmd.out_sel)
            OUT_DRAW: begin
               out_kind_ff  <= KIND_DRAW;
               out_col_ff   <= cur_col_ff;
               out_row_ff   <= cur_row_ff;
               out_char_ff  <= char_ff;
               out_color_ff <= color_ff;
            end
            OUT_ERASE: begin
               out_kind_ff  <= KIND_DRAW;
               out_col_ff   <= bs_col;
               out_row_ff   <= bs_row;
               out_char_ff  <= CHR_SPACE;
               out_color_ff <= 8'd0;
            end
            OUT_SCROLL: begin
               out_kind_ff  <= KIND_SCROLL;
               out_col_ff   <= 7'd0;
               out_row_ff   <= last_row;
               out_char_ff  <= CHR_SPACE;
               out_color_ff <= SCROLL_CLR;
            end
            OUT_CLEAR: begin
               out_kind_ff  <= KIND_CLEAR;
               out_col_ff   <= 7'd0;
               out_row_ff   <= 8'd0;
               out_char_ff  <= CHR_SPACE;
               out_color_ff <= color_ff;
            end
            default: begin
               out_kind_ff  <= KIND_CURSOR;
               out_col_ff   <= cur_col_ff;
               out_row_ff   <= cur_row_ff;
               out_char_ff  <= 8'd0;
               out_color_ff <= 8'd0;
               out_last_ff  <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {1'b0, out_color_ff, out_char_ff, out_row_ff, out_col_ff};

endmodule

`default_nettype wire

// ===== rtl/tcc_ctrl.sv =====
// tcc_ctrl: controller state machine sequencing each request beat
// depends on tcc_pkg
`default_nettype none

module tcc_ctrl
   import tcc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [1:0]   req_tuser,
   output tcc_cmd_type       cmd,
   input  wire tcc_stat_type stat
);

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_SAT      = 4'd2;
   localparam logic [3:0] ST_READ     = 4'd3;
   localparam logic [3:0] ST_EXEC     = 4'd4;
   localparam logic [3:0] ST_NEWLINE  = 4'd5;
   localparam logic [3:0] ST_SCR_RD   = 4'd6;
   localparam logic [3:0] ST_SCR_WR   = 4'd7;
   localparam logic [3:0] ST_SCR_ZERO = 4'd8;
   localparam logic [3:0] ST_SCR_EMIT = 4'd9;
   localparam logic [3:0] ST_CLR_EMIT = 4'd10;
   localparam logic [3:0] ST_MOVE     = 4'd11;
   localparam logic [3:0] ST_REPORT   = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       rep_ff, rep_in;

   assign req_tready = state_ff == ST_IDLE;

   always_comb begin
      state_in     = state_ff;
      rep_in       = rep_ff;
      cmd.item_load = 1'b0;
      cmd.out_load = 1'b0;
      cmd.out_sel  = OUT_REPORT;
      cmd.cur_op   = CUR_NONE;
      cmd.mem_op   = MEM_NONE;
      cmd.sweep_op = SWP_HOLD;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.mem_op   = MEM_WR_CLR;
            cmd.sweep_op = SWP_INC;
            if (stat.clr_last) begin
               state_in = rep_ff ? ST_REPORT : ST_IDLE;
               rep_in   = 1'b0;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.item_load = 1'b1;
               unique case (req_tuser)
                  OP_PUT:   state_in = ST_SAT;
                  OP_CLEAR: state_in = ST_CLR_EMIT;
                  OP_MOVE:  state_in = ST_MOVE;
                  OP_NONE:  state_in = ST_REPORT;
                  default:  state_in = ST_REPORT;
               endcase
            end
         end
         ST_SAT: begin
            cmd.cur_op = CUR_SAT;
            state_in   = ST_READ;
         end
         ST_READ: begin
            cmd.mem_op = MEM_RD_CUR;
            state_in   = ST_EXEC;
         end
         ST_EXEC: begin
            priority case (stat.char_class)
               CLS_PRINT: begin
                  if (stat.out_free) begin
                     cmd.out_load = 1'b1;
                     cmd.out_sel  = OUT_DRAW;
                     cmd.mem_op   = MEM_WR_DRAW;
                     if (stat.wrap) begin
                        state_in = ST_NEWLINE;
                     end else begin
                        cmd.cur_op = CUR_ADV;
                        state_in   = ST_REPORT;
                     end
                  end
               end
               CLS_NEWLINE: state_in = ST_NEWLINE;
               CLS_TAB: begin
                  if (stat.tab_wrap) begin
                     state_in = ST_NEWLINE;
                  end else begin
                     cmd.cur_op = CUR_TAB;
                     state_in   = ST_REPORT;
                  end
               end
               CLS_BS: begin
                  if (stat.bs_home) begin
                     state_in = ST_REPORT;
                  end else if (stat.out_free) begin
                     cmd.out_load = 1'b1;
                     cmd.out_sel  = OUT_ERASE;
                     cmd.cur_op   = CUR_BS;
                     cmd.mem_op   = MEM_WR_BS;
                     state_in     = ST_REPORT;
                  end
               end
               default: state_in = ST_REPORT;
            endcase
         end
         ST_NEWLINE: begin
            if (stat.scroll_needed) begin
               cmd.sweep_op = SWP_ONE;
               state_in     = stat.rows_multi ? ST_SCR_RD : ST_SCR_ZERO;
            end else begin
               cmd.cur_op = CUR_DOWN;
               state_in   = ST_REPORT;
            end
         end
         ST_SCR_RD: begin
            cmd.mem_op = MEM_RD_SWEEP;
            state_in   = ST_SCR_WR;
         end
         ST_SCR_WR: begin
            cmd.mem_op   = MEM_WR_SWEEP;
            cmd.sweep_op = SWP_INC;
            state_in     = stat.scr_more ? ST_SCR_RD : ST_SCR_ZERO;
         end
         ST_SCR_ZERO: begin
            cmd.mem_op = MEM_WR_BOTTOM;
            state_in   = ST_SCR_EMIT;
         end
         ST_SCR_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_SCROLL;
               cmd.cur_op   = CUR_BOTTOM;
               state_in     = ST_REPORT;
            end
         end
         ST_CLR_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_CLEAR;
               cmd.cur_op   = CUR_HOME;
               cmd.sweep_op = SWP_ZERO;
               rep_in       = 1'b1;
               state_in     = ST_CLEAR;
            end
         end
         ST_MOVE: begin
            cmd.cur_op = CUR_MOVE;
            state_in   = ST_REPORT;
         end
         ST_REPORT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_REPORT;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rep_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rep_ff   <= rep_in;
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb_text_console_cursor_control.sv =====
// tb_text_console_cursor_control: self-checking bench for the text console cursor block
// tracks cursor, row lengths and screen size to predict every result beat, checks in order
// depends on tcc_pkg and text_console_cursor_control
`default_nettype none

module tb_text_console_cursor_control;
   import tcc_pkg::*;

   localparam int ROW_CAP = 256;
   localparam int COL_CAP = 128;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 600;
   localparam int LONG_HOLD = 400;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [8:0]  csr_data;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] col;
      logic [7:0] row;
      logic [7:0] chr;
      logic [7:0] attr;
      logic       last;
   } console_event_type;

   class cursor_tracker_type;
      logic [7:0]        columns_reg;
      logic [8:0]        rows_reg;
      logic [6:0]        cur_col;
      logic [7:0]        cur_row;
      logic [7:0]        row_len [ROW_CAP];
      console_event_type due_events [$];
      int unsigned       errors;

      function new();
         columns_reg = 8'd80;
         rows_reg = 9'd25;
         cur_col = '0;
         cur_row = '0;
         foreach (row_len[i]) row_len[i] = '0;
         errors = 0;
      endfunction

      function void set_register(logic [7:0] idx, logic [8:0] data);
         if (idx == CSR_COLUMNS) begin
            columns_reg = data[7:0];
         end else if (idx == CSR_ROWS) begin
            rows_reg = data;
         end
      endfunction

      function int unsigned screen_cols();
         int unsigned c;
         c = 32'(columns_reg);
         if (c > COL_CAP) c = COL_CAP;
         if (c < 1) c = 1;
         return c;
      endfunction

      function int unsigned screen_rows();
         int unsigned r;
         r = 32'(rows_reg);
         if (r > ROW_CAP) r = ROW_CAP;
         if (r < 1) r = 1;
         return r;
      endfunction

      function void push(logic [1:0] kind, logic [6:0] col, logic [7:0] row,
                         logic [7:0] chr, logic [7:0] attr, logic last);
         console_event_type ev;
         ev.kind = kind;
         ev.col = col;
         ev.row = row;
         ev.chr = chr;
         ev.attr = attr;
         ev.last = last;
         due_events.push_back(ev);
      endfunction

      function void advance_line(int unsigned nrows);
         cur_col = '0;
         if (cur_row + 1 >= nrows) begin
            for (int r = 1; r < nrows; r++) row_len[r - 1] = row_len[r];
            row_len[nrows - 1] = '0;
            cur_row = 8'(nrows - 1);
            push(KIND_SCROLL, '0, 8'(nrows - 1), CHR_SPACE, SCROLL_CLR, 1'b0);
         end else begin
            cur_row = cur_row + 8'd1;
         end
      endfunction

      function void put_char(logic [7:0] ch, logic [7:0] attr);
         int unsigned ncols;
         int unsigned nrows;
         int unsigned nc;
         ncols = screen_cols();
         nrows = screen_rows();
         if (cur_col > ncols - 1) cur_col = 7'(ncols - 1);
         if (cur_row > nrows - 1) cur_row = 8'(nrows - 1);
         if (ch > CTRL_LAST && ch < 8'd128) begin
            push(KIND_DRAW, cur_col, cur_row, ch, attr, 1'b0);
            if (cur_col + 1 > row_len[cur_row]) row_len[cur_row] = 8'(cur_col + 1);
            if (cur_col + 1 >= ncols) advance_line(nrows);
            else cur_col = cur_col + 7'd1;
         end else if (ch == CHR_LF) begin
            advance_line(nrows);
         end else if (ch == CHR_TAB) begin
            nc = cur_col + 2 - cur_col[0];
            if (nc >= ncols) advance_line(nrows);
            else cur_col = 7'(nc);
         end else if (ch == CHR_BS) begin
            if (cur_col == 0) begin
               if (cur_row == 0) return;
               cur_row = cur_row - 8'd1;
               cur_col = 7'((row_len[cur_row] > ncols - 1) ? ncols - 1 : row_len[cur_row]);
            end else begin
               cur_col = cur_col - 7'd1;
            end
            push(KIND_DRAW, cur_col, cur_row, CHR_SPACE, 8'h00, 1'b0);
            if (cur_col < row_len[cur_row]) row_len[cur_row] = {1'b0, cur_col};
         end
      endfunction

      function void note_request(logic [1:0] op, logic [7:0] ch, logic [7:0] attr,
                                 logic [6:0] tcol, logic [7:0] trow);
         int unsigned ncols;
         int unsigned nrows;
         ncols = screen_cols();
         nrows = screen_rows();
         case (op)
            OP_PUT: begin
               put_char(ch, attr);
            end
            OP_CLEAR: begin
               foreach (row_len[i]) row_len[i] = '0;
               cur_col = '0;
               cur_row = '0;
               push(KIND_CLEAR, '0, '0, CHR_SPACE, attr, 1'b0);
            end
            OP_MOVE: begin
               cur_col = 7'((tcol > ncols - 1) ? ncols - 1 : tcol);
               cur_row = 8'((trow > nrows - 1) ? nrows - 1 : trow);
            end
            default: begin
            end
         endcase
         push(KIND_CURSOR, cur_col, cur_row, 8'h00, 8'h00, 1'b1);
      endfunction

      task report_mismatch(string msg);
         $display("ERROR at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_event(console_event_type got);
         console_event_type want;
         if (due_events.size() == 0) begin
            report_mismatch($sformatf("unexpected beat kind %0d", got.kind));
            return;
         end
         want = due_events.pop_front();
         if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
         if (got.col !== want.col)
            report_mismatch($sformatf("cell_col %0d, expected %0d", got.col, want.col));
         if (got.row !== want.row)
            report_mismatch($sformatf("cell_row %0d, expected %0d", got.row, want.row));
         if (got.chr !== want.chr)
            report_mismatch($sformatf("cell_char %0d, expected %0d", got.chr, want.chr));
         if (got.attr !== want.attr)
            report_mismatch($sformatf("cell_color %0d, expected %0d", got.attr, want.attr));
         if (got.last !== want.last)
            report_mismatch($sformatf("tlast %0d, expected %0d", got.last, want.last));
      endtask
   endclass

   cursor_tracker_type tracker = new();
   int unsigned rsp_beats = 0;

   text_console_cursor_control #(
      .MAX_ROW_COUNT(ROW_CAP),
      .MAX_COL_COUNT(COL_CAP)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // beat monitor: registers, requests and results as seen at the edge
   always @(posedge clock) begin
      console_event_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.set_register(csr_index, csr_data);
         if (req_tvalid && req_tready)
            tracker.note_request(req_tuser, req_tdata[7:0], req_tdata[15:8],
                                 req_tdata[22:16], req_tdata[30:23]);
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.col = rsp_tdata[6:0];
            got.row = rsp_tdata[14:7];
            got.chr = rsp_tdata[22:15];
            got.attr = rsp_tdata[30:23];
            got.last = rsp_tlast;
            tracker.check_event(got);
            rsp_beats++;
         end
      end
   end

   initial begin
      int unsigned idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) idle = 0;
         else idle++;
      end
      $display("Some tests failed");
      $finish;
   end

   // result side stall pattern, with one long hold-off
   initial begin
      int unsigned mode;
      int unsigned span;
      bit held_off;
      held_off = 0;
      rsp_tready <= 1'b0;
      forever begin
         if (!held_off && rsp_beats >= 200 && req_tvalid) begin
            held_off = 1;
            repeat (LONG_HOLD) begin
               @(posedge clock);
               rsp_tready <= 1'b0;
            end
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 60);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               2: rsp_tready <= ($urandom_range(0, 4) == 0);
               default: rsp_tready <= ~rsp_tready;
            endcase
         end
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                            input logic [7:0] attr, input logic [6:0] tcol,
                            input logic [7:0] trow);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {1'b0, trow, tcol, attr, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic put(input logic [7:0] ch, input logic [7:0] attr);
      send_item(OP_PUT, ch, attr, '0, '0);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.due_events.size() != 0) @(posedge clock);
   endtask

   task automatic set_screen(input logic [8:0] cols, input logic [8:0] rows);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_COLUMNS;
      csr_data <= cols;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_ROWS;
      csr_data <= rows;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_item(output logic [1:0] op, output logic [7:0] ch,
                              output logic [7:0] attr, output logic [6:0] tcol,
                              output logic [7:0] trow);
      int unsigned w;
      w = $urandom_range(0, 99);
      if (w < 4) op = OP_NONE;
      else if (w < 7) op = OP_CLEAR;
      else if (w < 15) op = OP_MOVE;
      else op = OP_PUT;
      w = $urandom_range(0, 99);
      if (w < 60) ch = 8'($urandom_range(32, 127));
      else if (w < 70) ch = CHR_LF;
      else if (w < 80) ch = CHR_TAB;
      else if (w < 93) ch = CHR_BS;
      else if (w < 97) ch = 8'($urandom_range(0, 31));
      else ch = 8'($urandom_range(128, 255));
      attr = 8'($urandom_range(0, 255));
      tcol = 7'($urandom_range(0, 1) ? $urandom_range(0, 127) : $urandom_range(0, 7));
      trow = 8'($urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 7));
   endtask

   task automatic run_random(input int unsigned count, input bit pause_mid);
      int unsigned useful;
      int unsigned burst;
      bit paused;
      logic [1:0] op;
      logic [7:0] ch;
      logic [7:0] attr;
      logic [6:0] tcol;
      logic [7:0] trow;
      useful = 0;
      paused = 0;
      while (useful < count) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            random_item(op, ch, attr, tcol, trow);
            send_item(op, ch, attr, tcol, trow);
            if (op == OP_CLEAR || op == OP_MOVE ||
                (op == OP_PUT && ((ch > CTRL_LAST && ch < 8'd128) || ch == CHR_LF ||
                                  ch == CHR_TAB || ch == CHR_BS)))
               useful++;
         end
         if (pause_mid && !paused && useful >= count / 2) begin
            paused = 1;
            wait_drained();
         end else if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= OP_PUT;
      csr_valid <= 1'b0;
      csr_index <= CSR_COLUMNS;
      csr_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed, at the reset screen size
      put(8'd32, 8'h00);
      put(8'd127, 8'hFF);
      put(CHR_TAB, 8'h12);
      put(8'd0, 8'h34);
      put(CTRL_LAST, 8'h56);
      put(8'd128, 8'h78);
      put(8'd255, 8'h9A);
      send_item(OP_MOVE, 8'h00, 8'h00, 7'd127, 8'd255);
      put(CHR_LF, 8'hBC);
      send_item(OP_NONE, 8'hFF, 8'hFF, 7'd127, 8'd255);
      send_item(OP_CLEAR, 8'h00, 8'hA5, '0, '0);
      put(CHR_BS, 8'h00);

      // directed, tiny screen: full-row backspace clamp, tab wrap, scrolls
      set_screen(9'd4, 9'd2);
      put("A", 8'h1F);
      put("B", 8'h2E);
      put("C", 8'h3D);
      put("D", 8'h4C);
      put(CHR_BS, 8'h00);
      put(CHR_BS, 8'h00);
      put(CHR_TAB, 8'h00);
      put("x", 8'hF0);
      put(CHR_LF, 8'h00);
      put(CHR_BS, 8'h00);
      send_item(OP_MOVE, 8'h00, 8'h00, 7'd127, 8'd255);
      put(CHR_TAB, 8'h00);

      set_screen(9'd0, 9'd0);
      run_random(20, 0);
      set_screen(9'h1FF, 9'd511);
      run_random(25, 0);
      set_screen(9'd128, 9'd256);
      run_random(20, 0);
      set_screen(9'd1, 9'd3);
      run_random(25, 0);
      set_screen(9'd7, 9'd3);
      run_random(65, 1);
      set_screen(9'd16, 9'd5);
      run_random(65, 0);
      set_screen(9'd3, 9'd1);
      run_random(35, 0);
      set_screen(9'($urandom_range(1, 20)), 9'($urandom_range(1, 6)));
      run_random(50, 0);
      set_screen(9'd80, 9'd25);
      run_random(50, 0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.due_events.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/tcc_pkg.sv
rtl/tcc_ram.sv
rtl/tcc_dp.sv
rtl/tcc_ctrl.sv
rtl/text_console_cursor_control.sv
tb/tb_text_console_cursor_control.sv
